### rtl/scbp_pkg.sv
// Shared constants, types and helpers of the size-class buffer pool.
`timescale 1ns / 1ps

package scbp_pkg;

   // Pool geometry
   localparam int POOL_DEPTH        = 128;
   localparam int HANDLE_BITS       = 16;
   localparam int NUM_CLASSES       = 7;
   localparam int NUM_SMALL_CLASSES = 2;
   localparam int STORE_DEPTH       = NUM_CLASSES * POOL_DEPTH;

   localparam int HEAD_W = $clog2(POOL_DEPTH);
   localparam int CNT_W  = $clog2(POOL_DEPTH + 1);
   localparam int SUM_W  = CNT_W + 1;
   localparam int ADDR_W = $clog2(STORE_DEPTH);

   // Field widths of the channels
   localparam int SIZE_W      = 32;
   localparam int REQ_HANDLE_W = 16;
   localparam int CLASS_W     = 3;
   localparam int STATUS_W    = 3;
   localparam int CAP_W       = 8;
   localparam int CSR_INDEX_W = 1;

   typedef logic [HEAD_W-1:0]       head_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [SUM_W-1:0]        sum_type;
   typedef logic [ADDR_W-1:0]       addr_type;
   typedef logic [HANDLE_BITS-1:0]  handle_type;
   typedef logic [CLASS_W-1:0]      class_type;
   typedef logic [SIZE_W-1:0]       size_type;
   typedef logic [CAP_W-1:0]        cap_type;

   // Class codes
   localparam class_type OVERSIZE_CLASS = 3'd7;

   // Operation codes
   localparam logic FUNC_GET     = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_SMALL_CAP = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LARGE_CAP = 1'b1;

   localparam cap_type SMALL_CAP_RESET = 8'd80;
   localparam cap_type LARGE_CAP_RESET = 8'd10;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_TAKEN         = 3'd0,
      STATUS_EMPTY_FRESH   = 3'd1,
      STATUS_OVERSIZE_NEED = 3'd2,
      STATUS_STORED        = 3'd3,
      STATUS_FULL_DROPPED  = 3'd4,
      STATUS_OVERSIZE_DROP = 3'd5
   } status_type;

   // Sequencer states
   typedef enum logic {
      S_IDLE = 1'b0,
      S_EXEC = 1'b1
   } fsm_type;

   // Class sizes in bytes, smallest first
   localparam size_type CLASS_BYTES [NUM_CLASSES] = '{
      32'd8, 32'd128, 32'd1224, 32'd4296, 32'd16584, 32'd32968, 32'd131272
   };

   // Smallest class whose size covers the request, else the oversize code
   function automatic class_type pick_class(size_type size);
      class_type c;
      c = OVERSIZE_CLASS;
      for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
         if (size <= CLASS_BYTES[i]) begin
            c = class_type'(i);
         end
      end
      return c;
   endfunction

endpackage

### rtl/scbp_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module scbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 896
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; read data holds until the next read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/size_class_buffer_pool_unit.sv
// Top level of the size-class buffer pool: sequencer, class state and handle store.
`timescale 1ns / 1ps

// Buffer-handle pool with seven size classes, each a FIFO free list held in
// its own region of one handle store RAM.
// Input: a command is transferred when start is high and busy is low. A get
// (req_func 0) pops the oldest handle of the smallest class that covers
// req_size; a release (req_func 1) pushes req_rel_handle if its class is
// below its cap.
// Result: every command gives exactly one result, shown for one cycle with
// rsp_valid high. The strobe rises once the command has passed the execute
// state and the result registers. The receiver cannot stall; results are
// never held.
// Operation: the class is computed and the command registered on transfer;
// the execute state reads the class head and count, updates them and issues
// the store read or write; the pop data comes out of the RAM read register
// with the result. busy is high in execute, so no new command is taken then.
// Configuration: csr_wr_en writes the cap selected by csr_index at once.
// Reset: all free lists empty, caps 80 for the two small classes and 10 for
// the others. No clearing pass is needed; only pushed entries are ever read.

module size_class_buffer_pool_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   // command channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_func,
   input  logic [scbp_pkg::SIZE_W-1:0]            req_size,
   input  logic [scbp_pkg::REQ_HANDLE_W-1:0]      req_rel_handle,
   // result channel
   output logic                                   rsp_valid,
   output logic [scbp_pkg::CLASS_W-1:0]           rsp_size_class,
   output logic [scbp_pkg::REQ_HANDLE_W-1:0]      rsp_out_handle,
   output logic [scbp_pkg::STATUS_W-1:0]          rsp_status,
   output logic [scbp_pkg::SIZE_W-1:0]            rsp_alloc_bytes,
   // configuration
   input  logic                                   csr_wr_en,
   input  logic [scbp_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [scbp_pkg::CAP_W-1:0]             csr_data
);

   scbp_pkg::fsm_type    state_ff, state_in;
   scbp_pkg::cap_type    small_cap_ff, large_cap_ff;

   // registered command
   logic                 cmd_func_ff;
   scbp_pkg::size_type   cmd_size_ff;
   scbp_pkg::handle_type cmd_handle_ff;
   scbp_pkg::class_type  cmd_class_ff;

   // per-class list state
   scbp_pkg::head_type   head_ff  [scbp_pkg::NUM_CLASSES];
   scbp_pkg::count_type  count_ff [scbp_pkg::NUM_CLASSES];

   // result registers
   logic                   rsp_valid_ff, rsp_valid_in;
   scbp_pkg::class_type    rsp_class_ff;
   scbp_pkg::status_type   rsp_status_ff, rsp_status_in;
   scbp_pkg::size_type     rsp_alloc_ff, rsp_alloc_in;

   logic                   accept;
   logic                   class_ok;
   scbp_pkg::class_type    class_idx;
   scbp_pkg::head_type     head_cur, head_in;
   scbp_pkg::count_type    count_cur, count_in, cap_eff;
   scbp_pkg::cap_type      cap_raw;
   scbp_pkg::sum_type      tail_sum;
   scbp_pkg::head_type     tail;
   scbp_pkg::addr_type     base_addr;
   logic                   ram_rd_en, ram_wr_en;
   scbp_pkg::handle_type   ram_rd_data;

   assign accept = start && (state_ff == scbp_pkg::S_IDLE);
   assign busy   = (state_ff == scbp_pkg::S_EXEC);

   // Sequencer: the command is registered on transfer in idle, then executed in exec
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         scbp_pkg::S_IDLE: begin
            if (accept) begin
               state_in = scbp_pkg::S_EXEC;
            end
         end
         scbp_pkg::S_EXEC: begin
            state_in = scbp_pkg::S_IDLE;
         end
         default: begin
            state_in = scbp_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= scbp_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         small_cap_ff <= scbp_pkg::SMALL_CAP_RESET;
         large_cap_ff <= scbp_pkg::LARGE_CAP_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            scbp_pkg::CSR_SMALL_CAP: small_cap_ff <= csr_data;
            scbp_pkg::CSR_LARGE_CAP: large_cap_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Capture the command and its class on transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_func_ff   <= req_func;
         cmd_size_ff   <= req_size;
         cmd_handle_ff <= scbp_pkg::handle_type'(req_rel_handle);
         cmd_class_ff  <= scbp_pkg::pick_class(req_size);
      end
   end

   // Look up the class state; the oversize code falls back to class 0 unused
   assign class_ok  = (cmd_class_ff != scbp_pkg::OVERSIZE_CLASS);
   assign class_idx = class_ok ? cmd_class_ff : '0;
   assign head_cur  = head_ff[class_idx];
   assign count_cur = count_ff[class_idx];

   // Effective cap, clipped to the region depth
   assign cap_raw = (int'(class_idx) < scbp_pkg::NUM_SMALL_CLASSES) ? small_cap_ff
                                                                     : large_cap_ff;
   assign cap_eff = (int'(cap_raw) > scbp_pkg::POOL_DEPTH)
                    ? scbp_pkg::count_type'(scbp_pkg::POOL_DEPTH)
                    : scbp_pkg::count_type'(cap_raw);

   // Tail slot, wrapped once within the region
   assign tail_sum = scbp_pkg::sum_type'(head_cur) + scbp_pkg::sum_type'(count_cur);
   assign tail = (tail_sum >= scbp_pkg::sum_type'(scbp_pkg::POOL_DEPTH))
                 ? scbp_pkg::head_type'(tail_sum - scbp_pkg::sum_type'(scbp_pkg::POOL_DEPTH))
                 : scbp_pkg::head_type'(tail_sum);

   assign base_addr = scbp_pkg::addr_type'(int'(class_idx) * scbp_pkg::POOL_DEPTH);

   // Decide the operation and the next class state
   always_comb begin
      ram_rd_en     = 1'b0;
      ram_wr_en     = 1'b0;
      head_in       = head_cur;
      count_in      = count_cur;
      rsp_alloc_in  = '0;
      rsp_status_in = scbp_pkg::STATUS_OVERSIZE_DROP;
      if (cmd_func_ff == scbp_pkg::FUNC_GET) begin
         priority if (!class_ok) begin
            rsp_status_in = scbp_pkg::STATUS_OVERSIZE_NEED;
            rsp_alloc_in  = cmd_size_ff;
         end else if (count_cur != '0) begin
            ram_rd_en     = busy;
            head_in       = (head_cur == scbp_pkg::head_type'(scbp_pkg::POOL_DEPTH - 1))
                            ? '0 : head_cur + 1'b1;
            count_in      = count_cur - 1'b1;
            rsp_status_in = scbp_pkg::STATUS_TAKEN;
         end else begin
            rsp_status_in = scbp_pkg::STATUS_EMPTY_FRESH;
            rsp_alloc_in  = scbp_pkg::CLASS_BYTES[class_idx];
         end
      end else begin
         priority if (!class_ok) begin
            rsp_status_in = scbp_pkg::STATUS_OVERSIZE_DROP;
         end else if (count_cur < cap_eff) begin
            ram_wr_en     = busy;
            count_in      = count_cur + 1'b1;
            rsp_status_in = scbp_pkg::STATUS_STORED;
         end else begin
            rsp_status_in = scbp_pkg::STATUS_FULL_DROPPED;
         end
      end
   end

   // Write back the class state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < scbp_pkg::NUM_CLASSES; i++) begin
            head_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else if (ram_rd_en || ram_wr_en) begin
         head_ff[class_idx]  <= head_in;
         count_ff[class_idx] <= count_in;
      end
   end

   // Result registers; the strobe lasts one cycle
   assign rsp_valid_in = busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (busy) begin
         rsp_class_ff  <= cmd_class_ff;
         rsp_status_ff <= rsp_status_in;
         rsp_alloc_ff  <= rsp_alloc_in;
      end
   end

   // Handle store; a command does at most one read or one write, never both
   scbp_ram #(
      .WIDTH (scbp_pkg::HANDLE_BITS),
      .DEPTH (scbp_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (base_addr + scbp_pkg::addr_type'(tail)),
      .wr_data (cmd_handle_ff),
      .rd_en   (ram_rd_en),
      .rd_addr (base_addr + scbp_pkg::addr_type'(head_cur)),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_size_class  = rsp_class_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_alloc_bytes = rsp_alloc_ff;
   assign rsp_out_handle  = (rsp_status_ff == scbp_pkg::STATUS_TAKEN)
                            ? scbp_pkg::REQ_HANDLE_W'(ram_rd_data) : '0;

`ifndef NO_ASSERTIONS
   // Every executed command yields exactly one result strobe in the next cycle
   a_rsp_follows_exec: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scbp_pkg::S_EXEC) |=> rsp_valid_ff)
      else $error("result strobe missing after execute cycle");

   a_rsp_only_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(state_ff == scbp_pkg::S_EXEC))
      else $error("result strobe without an executed command");

   // The store never sees a read and a write in the same cycle
   a_store_one_access: assert property (@(posedge clock) disable iff (reset)
      !(ram_rd_en && ram_wr_en))
      else $error("handle store read and write collide");

   // A class list never holds more than its region
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      busy |-> (int'(count_cur) <= scbp_pkg::POOL_DEPTH))
      else $error("class count exceeds region depth");

   // Execute always returns to idle, so no new command is taken while one executes
   a_exec_single: assert property (@(posedge clock) disable iff (reset)
      (state_ff == scbp_pkg::S_EXEC) |=> (state_ff == scbp_pkg::S_IDLE))
      else $error("execute state held for more than one cycle");
`endif

endmodule
